// ----- hw/rtl/ngf_pkg.sv -----
`timescale 1ns / 1ps

package ngf_pkg;

  // FNV-1 64-bit constants
  localparam logic [63:0] FnvPrime = 64'h0000_0100_0000_01b3;
  localparam logic [63:0] FnvBasis = 64'hcbf2_9ce4_8422_2325;

  // Word index inside one trigram request stream
  localparam logic [1:0] PosFirst = 2'd0;
  localparam logic [1:0] PosLast  = 2'd2;

  // Result queue
  localparam int unsigned ObufDepth = 2;
  localparam int unsigned ObufPtrW  = $clog2(ObufDepth);
  localparam int unsigned ObufCntW  = $clog2(ObufDepth + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       no_byte;
    logic       word_end;
  } in_item_t;

  typedef struct packed {
    logic [63:0] trigram_hash;
    logic [63:0] bigram_hash;
    logic [63:0] unigram_hash;
  } out_item_t;

endpackage

// ----- hw/rtl/ngram_fnv1_hasher.sv -----
`timescale 1ns / 1ps
// Output: a result is written into the result queue when the request that
// ends the third word is accepted, and leaves the queue from its head.
// Throughput: one request per cycle while the result queue is not full; the
// 64-bit accumulator update is combinational, and a two-entry result queue holds finished hashes.
// Reset: asynchronous, active low; accumulators return to the FNV offset
// basis, word position to zero, and the result queue empties.
module ngram_fnv1_hasher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ngf_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ngf_pkg::out_item_t out_item_o
);

  logic               take;
  logic               res_valid;
  ngf_pkg::out_item_t res;
  logic               buf_full;

  // Hold requests only while the result queue is full; any accepted request
  // may finish a trigram, so a free slot must always exist.
  assign in_stall_o = buf_full;
  assign take       = in_valid_i && !buf_full;

  // Accumulators advance on every accepted request that carries a byte; bytes
  // of a word absorb into the hashes that cover that word.
  ngf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .item_i      (in_item_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register stage: lets input keep flowing while a result waits.
  ngf_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_item_o)
  );

endmodule

// ----- hw/rtl/ngf_fnv_step.sv -----
`timescale 1ns / 1ps

// One FNV-1 step: multiply by the prime mod 2^64, then xor the byte.
// The prime is 2^40 + 0x1b3, so the product is a sum of seven shifted copies.
module ngf_fnv_step (
  input  logic [63:0] acc_i,
  input  logic [7:0]  byte_i,
  output logic [63:0] acc_o
);

  logic [63:0] prod;

  assign prod = acc_i
              + (acc_i << 1)
              + (acc_i << 4)
              + (acc_i << 5)
              + (acc_i << 7)
              + (acc_i << 8)
              + (acc_i << 40);

  assign acc_o = prod ^ {56'd0, byte_i};

endmodule

// ----- hw/rtl/ngf_core.sv -----
`timescale 1ns / 1ps

// Three running accumulators and the word position; one request per cycle while take_i is high.
module ngf_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  ngf_pkg::in_item_t item_i,
  output logic              res_valid_o,
  output ngf_pkg::out_item_t res_o
);

  logic [1:0]  pos_q, pos_d;
  logic [63:0] tri_q, tri_d;
  logic [63:0] bi_q, bi_d;
  logic [63:0] uni_q, uni_d;
  logic [63:0] tri_step, bi_step, uni_step;
  logic        has_byte;
  logic        last_word;

  ngf_fnv_step u_tri (.acc_i(tri_q), .byte_i(item_i.data_byte), .acc_o(tri_step));
  ngf_fnv_step u_bi  (.acc_i(bi_q),  .byte_i(item_i.data_byte), .acc_o(bi_step));
  ngf_fnv_step u_uni (.acc_i(uni_q), .byte_i(item_i.data_byte), .acc_o(uni_step));

  assign has_byte  = !item_i.no_byte;
  assign last_word = (pos_q >= ngf_pkg::PosLast);

  always_comb begin
    tri_d = tri_q;
    bi_d  = bi_q;
    uni_d = uni_q;
    pos_d = pos_q;
    if (has_byte) begin
      tri_d = tri_step;
      if (pos_q != ngf_pkg::PosFirst) bi_d = bi_step;
      if (last_word) uni_d = uni_step;
    end
    // Emit from the updated values; at a word end, restart after the third word, else advance the position
    res_o.trigram_hash = tri_d;
    res_o.bigram_hash  = bi_d;
    res_o.unigram_hash = uni_d;
    res_valid_o        = take_i && item_i.word_end && last_word;
    if (item_i.word_end) begin
      if (last_word) begin
        tri_d = ngf_pkg::FnvBasis;
        bi_d  = ngf_pkg::FnvBasis;
        uni_d = ngf_pkg::FnvBasis;
        pos_d = ngf_pkg::PosFirst;
      end else begin
        pos_d = pos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= ngf_pkg::PosFirst;
      tri_q <= ngf_pkg::FnvBasis;
      bi_q  <= ngf_pkg::FnvBasis;
      uni_q <= ngf_pkg::FnvBasis;
    end else if (take_i) begin
      pos_q <= pos_d;
      tri_q <= tri_d;
      bi_q  <= bi_d;
      uni_q <= uni_d;
    end
  end

endmodule

// ----- hw/rtl/ngf_out_buf.sv -----
`timescale 1ns / 1ps

// Small result queue; full flag is taken from the registered count so input stall has no path
// from the output side.
module ngf_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ngf_pkg::out_item_t data_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               stall_i,
  output ngf_pkg::out_item_t data_o
);

  ngf_pkg::out_item_t mem_q [ngf_pkg::ObufDepth];
  logic [ngf_pkg::ObufPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [ngf_pkg::ObufCntW-1:0] cnt_q;
  logic pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == ngf_pkg::ObufCntW'(ngf_pkg::ObufDepth));
  assign pop     = valid_o && !stall_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
